FILE: rtl/odo_pkg.sv
// Shared constants, tables and width helpers for the odometry block.
package odo_pkg;

   // Default parameter values.
   localparam int FRAC_BITS_DEF    = 8;
   localparam int CORDIC_STEPS_DEF = 16;

   // Fixed field widths.
   localparam int ANGLE_W = 32;
   localparam int HEAD_W  = 17;
   localparam int POS_W   = 32;
   localparam int WT_W    = 16;
   localparam int DATA_W  = 32;
   localparam int CSR_IDX_W = 2;

   // Reset value of the wheel circumference.
   localparam int WT_RESET = 5120;

   // Sum of the two encoder deltas.
   localparam int SUM_W = ANGLE_W + 2;

   // 720 = TURN_DIV << TURN_SHIFT.
   localparam int TURN_DIV   = 45;
   localparam int TURN_SHIFT = 4;

   // CORDIC datapath.
   localparam int MAX_STEPS = 24;
   localparam int STEP_W    = 5;
   localparam int ANG_FRAC  = 24;
   localparam int XY_W      = 33;
   localparam int Z_W       = 34;
   localparam int SC_SHIFT  = 4;
   localparam int SC_W      = XY_W - SC_SHIFT;
   localparam int INC_SHIFT = 26;
   localparam int GAIN_Q30  = 652032874;

   // Arctangent of 2^-i in degrees, 24 fraction bits.
   localparam logic [29:0] ATAN_Q24 [MAX_STEPS] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 2'd0,
      CSR_START_Y = 2'd1,
      CSR_WHEEL   = 2'd2
   } csr_index_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of the doubled mid heading, wide enough for a full turn at any scale.
   function automatic int mid_width(input int frac);
      return max_int(20, frac + 11);
   endfunction

   // Width of the travel numerator after the power-of-two part of the divide.
   function automatic int q1_width(input int frac);
      return SUM_W + WT_W + 1 - frac - TURN_SHIFT;
   endfunction

   // Width of the signed travel after dividing by TURN_DIV.
   function automatic int trav_width(input int frac);
      return q1_width(frac) - ($clog2(TURN_DIV) - 1);
   endfunction

endpackage

FILE: rtl/diff_drive_odometry.sv
// Top level of the differential drive odometry block: sequencer, state and ports.
// A reference beat (first after reset or a start position write) answers in the next cycle.
// Any other beat runs through the travel product, the radix-4 divide by 45 and the CORDIC;
// at the default parameters the CORDIC runs beside the divider and is hidden.
// One beat is in work at a time; a new beat is taken in the cycle its result leaves.
// Synchronous reset zeroes the position, sets a 20 cm wheel and drops the reference.
module diff_drive_odometry import odo_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ANGLE_W-1:0] req_left_angle,
   input  logic signed [ANGLE_W-1:0] req_right_angle,
   input  logic [HEAD_W-1:0]         req_compass,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic                      rsp_was_first,
   output logic                      rsp_saturated,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DATA_W-1:0]         csr_wdata
);

   // Widths that follow from the number of fraction bits.
   localparam int MID_W   = mid_width(FRAC_BITS);
   localparam int Q1_W    = q1_width(FRAC_BITS);
   localparam int TRAV_W  = trav_width(FRAC_BITS);
   localparam int DL_W    = ANGLE_W + 1;
   localparam int N_W     = SUM_W + WT_W + 1;
   localparam int MUL_A_W = max_int(SUM_W, TRAV_W);
   localparam int MUL_B_W = SC_W;
   localparam int P_W     = MUL_A_W + MUL_B_W;
   localparam int INC_W   = P_W - INC_SHIFT;
   localparam int ACC_S_W = INC_W + 1;

   // Heading constants at FRAC_BITS fraction bits.
   localparam logic signed [MID_W-1:0] HALF_TURN  = MID_W'(180 << FRAC_BITS);
   localparam logic signed [MID_W-1:0] NHALF_TURN = -HALF_TURN;
   localparam logic signed [MID_W-1:0] FULL_TURN  = MID_W'(360 << FRAC_BITS);
   // Half of the travel divisor 720 << FRAC_BITS, for round half up.
   localparam logic signed [N_W-1:0]   HALF_D     = N_W'(360 << FRAC_BITS);
   localparam logic signed [P_W-1:0]   RND        = P_W'(1) <<< (INC_SHIFT - 1);
   localparam logic signed [ACC_S_W-1:0] POS_MAX  = (ACC_S_W'(1) <<< (POS_W - 1)) - 1;
   localparam logic signed [ACC_S_W-1:0] POS_MIN  = -(ACC_S_W'(1) <<< (POS_W - 1));

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_MUL_T  = 9'b0_0000_0010,
      ST_DIV_LD = 9'b0_0000_0100,
      ST_DIV_GO = 9'b0_0000_1000,
      ST_WAIT   = 9'b0_0001_0000,
      ST_MUL_S  = 9'b0_0010_0000,
      ST_MUL_C  = 9'b0_0100_0000,
      ST_ACC_X  = 9'b0_1000_0000,
      ST_ACC_Y  = 9'b1_0000_0000
   } seq_state_type;

   // Sequencer and reference state.
   seq_state_type              state_ff, state_in;
   logic                       primed_ff, primed_in;
   logic signed [ANGLE_W-1:0]  prev_left_ff, prev_left_in;
   logic signed [ANGLE_W-1:0]  prev_right_ff, prev_right_in;
   logic [HEAD_W-1:0]          prev_head_ff, prev_head_in;
   logic signed [POS_W-1:0]    acc_x_ff, acc_x_in;
   logic signed [POS_W-1:0]    acc_y_ff, acc_y_in;
   logic [WT_W-1:0]            wheel_ff, wheel_in;

   // Per-beat working registers.
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [MID_W-1:0]    mid2_ff, mid2_in;
   logic signed [N_W-1:0]      n_ff, n_in;
   logic signed [INC_W-1:0]    inc_x_ff, inc_x_in;
   logic signed [INC_W-1:0]    inc_y_ff, inc_y_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       first_ff, first_in;
   logic                       sat_ff, sat_in;

   // Handshakes.
   logic                       req_accept;
   logic                       rsp_take;
   logic                       csr_write;

   // Delta and heading path for an accepted beat.
   logic signed [DL_W-1:0]     delta_left;
   logic signed [DL_W-1:0]     delta_right;
   logic signed [SUM_W-1:0]    delta_sum;
   logic signed [MID_W-1:0]    dh_raw;
   logic signed [MID_W-1:0]    dh_wrap;
   logic signed [MID_W-1:0]    mid2_new;

   // Shared multiplier, divider and CORDIC.
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [P_W-1:0]      mul_p;
   logic signed [INC_W-1:0]    inc_round;
   logic                       div_start;
   logic signed [Q1_W-1:0]     div_numer;
   logic                       div_done;
   logic signed [TRAV_W-1:0]   travel;
   logic                       cor_start;
   logic                       cor_done;
   logic signed [SC_W-1:0]     sin_q26;
   logic signed [SC_W-1:0]     cos_q26;

   // Shared saturating accumulator adder.
   logic signed [POS_W-1:0]    sat_acc;
   logic signed [INC_W-1:0]    sat_inc;
   logic signed [ACC_S_W-1:0]  sat_sum;
   logic signed [POS_W-1:0]    sat_res;
   logic                       sat_hit;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   // Registers are written only while no beat is in work and no result is pending.
   assign csr_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_write  = csr_valid && csr_ready;

   // A beat is taken only in idle, only once any pending result leaves this cycle, and
   // never while a register write is offered.
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall) || csr_valid;

   // Encoder deltas are exact at 33 bits and their sum at 34 bits.
   assign delta_left  = DL_W'(req_left_angle) - DL_W'(prev_left_ff);
   assign delta_right = DL_W'(req_right_angle) - DL_W'(prev_right_ff);
   assign delta_sum   = SUM_W'(delta_left) + SUM_W'(delta_right);

   // The heading change is wrapped once into half a turn either way, and the mid
   // heading is kept doubled so that it stays exact with one more fraction bit.
   assign dh_raw = signed'(MID_W'(req_compass)) - signed'(MID_W'(prev_head_ff));

   always_comb begin
      priority if (dh_raw > HALF_TURN) begin
         dh_wrap = dh_raw - FULL_TURN;
      end else if (dh_raw < NHALF_TURN) begin
         dh_wrap = dh_raw + FULL_TURN;
      end else begin
         dh_wrap = dh_raw;
      end
   end

   assign mid2_new = (signed'(MID_W'(prev_head_ff)) <<< 1) + dh_wrap;

   // The travel numerator is divided by 16 << FRAC_BITS with a floor shift here,
   // and by 45 in the serial divider.
   assign div_numer = signed'(n_ff[N_W-1 -: Q1_W]);

   // Each increment is the product rounded half up from Q26.
   assign inc_round = INC_W'((mul_p + RND) >>> INC_SHIFT);

   // One saturating add serves both axes.
   assign sat_acc = (state_ff == ST_ACC_X) ? acc_x_ff : acc_y_ff;
   assign sat_inc = (state_ff == ST_ACC_X) ? inc_x_ff : inc_y_ff;
   assign sat_sum = ACC_S_W'(sat_acc) + ACC_S_W'(sat_inc);

   always_comb begin
      priority if (sat_sum > POS_MAX) begin
         sat_res = POS_W'(POS_MAX);
         sat_hit = 1'b1;
      end else if (sat_sum < POS_MIN) begin
         sat_res = POS_W'(POS_MIN);
         sat_hit = 1'b1;
      end else begin
         sat_res = POS_W'(sat_sum);
         sat_hit = 1'b0;
      end
   end

   // Sequencer. The CORDIC starts together with the travel product and, at the default
   // parameters, finishes before the divider, so the wait state is then set by the divider.
   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      prev_head_in  = prev_head_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      wheel_in      = wheel_ff;
      sum_in        = sum_ff;
      mid2_in       = mid2_ff;
      n_in          = n_ff;
      inc_x_in      = inc_x_ff;
      inc_y_in      = inc_y_ff;
      first_in      = first_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      cor_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               prev_left_in  = req_left_angle;
               prev_right_in = req_right_angle;
               prev_head_in  = req_compass;
               first_in      = !primed_ff;
               sat_in        = 1'b0;
               if (!primed_ff) begin
                  // Reference beat: the position stays as it is.
                  primed_in    = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  sum_in   = delta_sum;
                  mid2_in  = mid2_new;
                  state_in = ST_MUL_T;
               end
            end
         end
         ST_MUL_T: begin
            mul_a     = MUL_A_W'(sum_ff);
            mul_b     = signed'(MUL_B_W'(wheel_ff));
            cor_start = 1'b1;
            state_in  = ST_DIV_LD;
         end
         ST_DIV_LD: begin
            n_in     = N_W'(mul_p) + HALF_D;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done && cor_done) begin
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: begin
            mul_a    = MUL_A_W'(travel);
            mul_b    = sin_q26;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            mul_a    = MUL_A_W'(travel);
            mul_b    = cos_q26;
            inc_x_in = inc_round;
            state_in = ST_ACC_X;
         end
         ST_ACC_X: begin
            inc_y_in = inc_round;
            acc_x_in = sat_res;
            sat_in   = sat_ff || sat_hit;
            state_in = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            acc_y_in     = sat_res;
            sat_in       = sat_ff || sat_hit;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes. A start position write restarts the reference.
      if (csr_write) begin
         unique case (csr_index)
            CSR_START_X: begin
               acc_x_in  = signed'(POS_W'(csr_wdata));
               primed_in = 1'b0;
            end
            CSR_START_Y: begin
               acc_y_in  = signed'(POS_W'(csr_wdata));
               primed_in = 1'b0;
            end
            CSR_WHEEL: begin
               wheel_in = csr_wdata[WT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         wheel_ff     <= WT_W'(WT_RESET);
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         wheel_ff     <= wheel_in;
      end
      prev_left_ff  <= prev_left_in;
      prev_right_ff <= prev_right_in;
      prev_head_ff  <= prev_head_in;
      sum_ff        <= sum_in;
      mid2_ff       <= mid2_in;
      n_ff          <= n_in;
      inc_x_ff      <= inc_x_in;
      inc_y_ff      <= inc_y_in;
      first_ff      <= first_in;
      sat_ff        <= sat_in;
   end

   odo_mult #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mult (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   odo_cdiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .done  (div_done),
      .quot  (travel)
   );

   odo_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .mid2    (mid2_ff),
      .done    (cor_done),
      .sin_q26 (sin_q26),
      .cos_q26 (cos_q26)
   );

   // The position outputs come straight from the accumulators, which only move
   // while no result is pending.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = acc_x_ff;
   assign rsp_pos_y     = acc_y_ff;
   assign rsp_was_first = first_ff;
   assign rsp_saturated = sat_ff;

   // A result is never pending while a beat is in work.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a beat is in work");

   // A reference beat answers in the next cycle and leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !primed_ff) |=> (rsp_valid_ff && first_ff && (state_ff == ST_IDLE)))
      else $error("reference beat did not answer at once");

   // A reference beat never reports saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(first_ff && sat_ff))
      else $error("reference beat reports saturation");

endmodule

FILE: rtl/odo_mult.sv
// Registered signed multiplier shared by all products of the block.
module odo_mult import odo_pkg::*; #(
   parameter int A_W = SUM_W,
   parameter int B_W = SC_W
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);

   logic signed [A_W+B_W-1:0] p_ff;
   logic signed [A_W+B_W-1:0] p_in;

   assign p_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

FILE: rtl/odo_cdiv.sv
// Radix-4 serial floor division of a signed value by the constant TURN_DIV.
module odo_cdiv import odo_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int IN_W  = q1_width(FRAC_BITS),
   localparam int OUT_W = trav_width(FRAC_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [IN_W-1:0]  numer,
   output logic                    done,
   output logic signed [OUT_W-1:0] quot
);

   localparam int DIV_W = IN_W + (IN_W % 2);
   localparam int STEPS = DIV_W / 2;
   localparam int CNT_W = $clog2(STEPS);
   localparam int R_W   = $clog2(TURN_DIV);
   localparam int RX_W  = R_W + 2;
   localparam logic [RX_W-1:0] D1 = RX_W'(TURN_DIV);
   localparam logic [RX_W-1:0] D2 = RX_W'(2 * TURN_DIV);
   localparam logic [RX_W-1:0] D3 = RX_W'(3 * TURN_DIV);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   typedef enum logic [2:0] {
      D_IDLE   = 3'b001,
      D_RUN    = 3'b010,
      D_FINISH = 3'b100
   } div_state_type;

   div_state_type            state_ff, state_in;
   logic [DIV_W-1:0]         work_ff, work_in;
   logic [R_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic                     done_ff, done_in;
   logic signed [OUT_W-1:0]  quot_ff, quot_in;
   logic [IN_W-1:0]          mag;
   logic [RX_W-1:0]          rx;
   logic [RX_W-1:0]          rx_left;
   logic [1:0]               digit;

   // For a negative numerator, floor(n/d) = -((|n| + d - 1) / d).
   assign mag = numer[IN_W-1] ? (~numer + IN_W'(TURN_DIV - 1) + IN_W'(1)) : numer;
   assign rx  = {rem_ff, work_ff[DIV_W-1 -: 2]};

   always_comb begin
      priority if (rx >= D3) begin
         digit   = 2'd3;
         rx_left = rx - D3;
      end else if (rx >= D2) begin
         digit   = 2'd2;
         rx_left = rx - D2;
      end else if (rx >= D1) begin
         digit   = 2'd1;
         rx_left = rx - D1;
      end else begin
         digit   = 2'd0;
         rx_left = rx;
      end
   end

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = done_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               work_in  = DIV_W'(mag);
               rem_in   = '0;
               cnt_in   = '0;
               neg_in   = numer[IN_W-1];
               done_in  = 1'b0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            work_in = {work_ff[DIV_W-3:0], digit};
            rem_in  = R_W'(rx_left);
            if (cnt_ff == LAST) begin
               state_in = D_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         D_FINISH: begin
            quot_in  = neg_ff ? -signed'(OUT_W'(work_ff)) : signed'(OUT_W'(work_ff));
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/odo_cordic.sv
// Iterative CORDIC: reduces the doubled mid heading and returns sin and cos in Q26.
module odo_cordic import odo_pkg::*; #(
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   localparam int MID_W = mid_width(FRAC_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [MID_W-1:0] mid2,
   output logic                    done,
   output logic signed [SC_W-1:0]  sin_q26,
   output logic signed [SC_W-1:0]  cos_q26
);

   // The angle carries FRAC_BITS+1 fraction bits, so one turn is 720 << FRAC_BITS.
   localparam logic signed [MID_W-1:0] FULL2   = MID_W'(720 << FRAC_BITS);
   localparam logic signed [MID_W-1:0] HALF2   = MID_W'(360 << FRAC_BITS);
   localparam logic signed [MID_W-1:0] NHALF2  = -HALF2;
   localparam logic signed [MID_W-1:0] QUART2  = MID_W'(180 << FRAC_BITS);
   localparam logic signed [MID_W-1:0] NQUART2 = -QUART2;
   localparam int SCALE = ANG_FRAC - 1 - FRAC_BITS;
   localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [3:0] {
      C_IDLE   = 4'b0001,
      C_REDUCE = 4'b0010,
      C_ROTATE = 4'b0100,
      C_FINISH = 4'b1000
   } cordic_state_type;

   cordic_state_type         state_ff, state_in;
   logic signed [MID_W-1:0]  t_ff, t_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic                     flip_ff, flip_in;
   logic                     done_ff, done_in;
   logic signed [SC_W-1:0]   sin_ff, sin_in;
   logic signed [SC_W-1:0]   cos_ff, cos_in;
   logic signed [MID_W-1:0]  fold_t;
   logic                     fold_flip;
   logic signed [XY_W-1:0]   x_sh;
   logic signed [XY_W-1:0]   y_sh;
   logic signed [Z_W-1:0]    atan_z;
   logic signed [XY_W-1:0]   x_out;
   logic signed [XY_W-1:0]   y_out;

   // Fold the reduced angle into the right half plane.
   always_comb begin
      priority if (t_ff > QUART2) begin
         fold_t    = t_ff - HALF2;
         fold_flip = 1'b1;
      end else if (t_ff < NQUART2) begin
         fold_t    = t_ff + HALF2;
         fold_flip = 1'b1;
      end else begin
         fold_t    = t_ff;
         fold_flip = 1'b0;
      end
   end

   assign x_sh   = x_ff >>> cnt_ff;
   assign y_sh   = y_ff >>> cnt_ff;
   assign atan_z = signed'(Z_W'(ATAN_Q24[cnt_ff]));
   assign x_out  = flip_ff ? -x_ff : x_ff;
   assign y_out  = flip_ff ? -y_ff : y_ff;

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cnt_in   = cnt_ff;
      flip_in  = flip_ff;
      done_in  = done_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               t_in     = mid2;
               done_in  = 1'b0;
               state_in = C_REDUCE;
            end
         end
         C_REDUCE: begin
            // One turn per cycle until the angle lies in [-180, 180).
            priority if (t_ff >= HALF2) begin
               t_in = t_ff - FULL2;
            end else if (t_ff < NHALF2) begin
               t_in = t_ff + FULL2;
            end else begin
               z_in     = Z_W'(fold_t) <<< SCALE;
               flip_in  = fold_flip;
               x_in     = XY_W'(GAIN_Q30);
               y_in     = '0;
               cnt_in   = '0;
               state_in = C_ROTATE;
            end
         end
         C_ROTATE: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_z;
            end
            if (cnt_ff == LAST) begin
               state_in = C_FINISH;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         C_FINISH: begin
            cos_in   = SC_W'(x_out >>> SC_SHIFT);
            sin_in   = SC_W'(y_out >>> SC_SHIFT);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      t_ff    <= t_in;
      z_ff    <= z_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      cnt_ff  <= cnt_in;
      flip_ff <= flip_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign done    = done_ff;
   assign sin_q26 = sin_ff;
   assign cos_q26 = cos_ff;

endmodule

FILE: test/odo_checker.sv
// Checker for the odometry block: predicts each position result and compares it with the output.
module odo_checker import odo_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [ANGLE_W-1:0] req_left_angle,
   input  logic signed [ANGLE_W-1:0] req_right_angle,
   input  logic [HEAD_W-1:0]         req_compass,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [POS_W-1:0]   rsp_pos_x,
   input  logic signed [POS_W-1:0]   rsp_pos_y,
   input  logic                      rsp_was_first,
   input  logic                      rsp_saturated,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DATA_W-1:0]         csr_wdata,
   output int                        mismatches,
   output int                        outstanding
);

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    was_first;
      logic                    saturated;
   } pose_type;

   localparam int     FRAC       = 8;
   localparam int     STEPS      = 16;
   localparam longint HALF_TURN  = longint'(180) << FRAC;
   localparam longint FULL_TURN  = longint'(360) << FRAC;
   localparam longint DIVISOR    = longint'(720) << FRAC;
   localparam longint TURN_Q24   = longint'(360) << 24;
   localparam longint HALF_Q24   = longint'(180) << 24;
   localparam longint QUART_Q24  = longint'(90) << 24;
   localparam longint GAIN       = 652032874;
   localparam longint POS_MAX    = 64'sd2147483647;
   localparam longint POS_MIN    = -64'sd2147483648;
   localparam longint ARCTAN_Q24 [STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335
   };

   longint   origin_x, origin_y, circumference;
   longint   last_left, last_right, last_heading;
   longint   track_x, track_y;
   bit       has_reference;
   pose_type pending_poses[$];

   function automatic longint div_floor(input longint num, input longint den);
      if (num >= 0)
         return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic longint clamp_pos(input longint v, inout bit hit);
      if (v > POS_MAX) begin
         hit = 1'b1;
         return POS_MAX;
      end
      if (v < POS_MIN) begin
         hit = 1'b1;
         return POS_MIN;
      end
      return v;
   endfunction

   // Angle in degrees with 24 fraction bits; sine and cosine come back in Q26.
   function automatic void heading_sin_cos(input longint ang, output longint sin_q26,
                                           output longint cos_q26);
      longint t, cx, cy, xs, ys;
      bit     flip;
      int     i;
      t = ang % TURN_Q24;
      if (t < 0) t += TURN_Q24;
      if (t >= HALF_Q24) t -= TURN_Q24;
      flip = 1'b0;
      if (t > QUART_Q24) begin
         t -= HALF_Q24;
         flip = 1'b1;
      end else if (t < -QUART_Q24) begin
         t += HALF_Q24;
         flip = 1'b1;
      end
      cx = GAIN;
      cy = 0;
      for (i = 0; i < STEPS; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (t >= 0) begin
            cx -= ys;
            cy += xs;
            t  -= ARCTAN_Q24[i];
         end else begin
            cx += ys;
            cy -= xs;
            t  += ARCTAN_Q24[i];
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      cos_q26 = cx >>> 4;
      sin_q26 = cy >>> 4;
   endfunction

   // Advances the position estimate by one sample and returns the pose it reports.
   function automatic pose_type dead_reckon(input longint left, input longint right,
                                            input longint heading);
      pose_type p;
      longint   span, travel, dh, mid2, s, c;
      bit       hit;
      hit = 1'b0;
      p.was_first = 1'b0;
      if (!has_reference) begin
         has_reference = 1'b1;
         p.was_first   = 1'b1;
      end else begin
         span   = (left - last_left) + (right - last_right);
         travel = div_floor(span * circumference + DIVISOR / 2, DIVISOR);
         dh     = heading - last_heading;
         if (dh > HALF_TURN) dh -= FULL_TURN;
         else if (dh < -HALF_TURN) dh += FULL_TURN;
         mid2 = 2 * last_heading + dh;
         heading_sin_cos(mid2 * (longint'(1) << (24 - 1 - FRAC)), s, c);
         track_x = clamp_pos(track_x + ((travel * s + (longint'(1) << 25)) >>> 26), hit);
         track_y = clamp_pos(track_y + ((travel * c + (longint'(1) << 25)) >>> 26), hit);
      end
      last_left    = left;
      last_right   = right;
      last_heading = heading;
      p.pos_x      = track_x[POS_W-1:0];
      p.pos_y      = track_y[POS_W-1:0];
      p.saturated  = hit;
      return p;
   endfunction

   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         origin_x      = 0;
         origin_y      = 0;
         circumference = 5120;
         last_left     = 0;
         last_right    = 0;
         last_heading  = 0;
         track_x       = 0;
         track_y       = 0;
         has_reference = 1'b0;
         pending_poses.delete();
         mismatches    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_START_X: begin
                  origin_x      = longint'($signed(csr_wdata));
                  track_x       = origin_x;
                  has_reference = 1'b0;
               end
               CSR_START_Y: begin
                  origin_y      = longint'($signed(csr_wdata));
                  track_y       = origin_y;
                  has_reference = 1'b0;
               end
               CSR_WHEEL: circumference = longint'(csr_wdata[WT_W-1:0]);
               default: ;
            endcase
         end
         // Retire the response before queuing a new sample so that a beat leaving in the
         // same cycle can never match the expectation of the sample just taken.
         if (rsp_valid && !rsp_stall) begin
            if (pending_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: x=%0d y=%0d first=%0b sat=%0b",
                           rsp_pos_x, rsp_pos_y, rsp_was_first, rsp_saturated);
            end else begin
               want = pending_poses.pop_front();
               if (rsp_pos_x !== want.pos_x || rsp_pos_y !== want.pos_y ||
                   rsp_was_first !== want.was_first || rsp_saturated !== want.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result mismatch: expected x=%0d y=%0d first=%0b sat=%0b, ",
                               "got x=%0d y=%0d first=%0b sat=%0b"},
                              want.pos_x, want.pos_y, want.was_first, want.saturated,
                              rsp_pos_x, rsp_pos_y, rsp_was_first, rsp_saturated);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_poses.push_back(dead_reckon(longint'(req_left_angle),
                                                longint'(req_right_angle),
                                                longint'(req_compass)));
      end
      outstanding = pending_poses.size();
   end

endmodule

FILE: test/tb_diff_drive_odometry.sv
// Testbench top for the odometry block: clock, reset, stimulus, stall pattern and verdict.
module tb_diff_drive_odometry import odo_pkg::*;;

   // Index that decodes to no register; writes to it must leave the block untouched.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // The watchdog gives up after this many cycles without any beat on any channel. The
   // longest quiet stretch in a correct run is the receiver's long hold-off plus one sample.
   localparam int QUIET_LIMIT = 5000;
   // After this many result beats the receiver stalls for a long stretch so that the block
   // fills up and has to stall the sample channel.
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 400;
   // Result beats in this window are taken without any stall.
   localparam int CALM_FROM   = 300;
   localparam int CALM_TO     = 420;
   // Long enough to cover one more sample in flight.
   localparam int SETTLE      = 60;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [ANGLE_W-1:0] req_left_angle = '0;
   logic signed [ANGLE_W-1:0] req_right_angle = '0;
   logic [HEAD_W-1:0]         req_compass = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [POS_W-1:0]   rsp_pos_x;
   logic signed [POS_W-1:0]   rsp_pos_y;
   logic                      rsp_was_first;
   logic                      rsp_saturated;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [DATA_W-1:0]         csr_wdata = '0;

   int mismatches;
   int outstanding;

   // When set, the sender offers samples back to back with no idle cycles.
   bit sender_calm = 1'b0;

   // Encoder and compass readings of the simulated robot.
   logic signed [ANGLE_W-1:0] cur_left = '0;
   logic signed [ANGLE_W-1:0] cur_right = '0;
   int                        cur_head = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   diff_drive_odometry u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_angle  (req_left_angle),
      .req_right_angle (req_right_angle),
      .req_compass     (req_compass),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_was_first   (rsp_was_first),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   odo_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_angle  (req_left_angle),
      .req_right_angle (req_right_angle),
      .req_compass     (req_compass),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_was_first   (rsp_was_first),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // Offers one sample and returns at the edge where the beat is taken. The valid is left
   // high so that the next sample can follow without a bubble; the caller lowers it.
   task automatic send_sample(input logic signed [ANGLE_W-1:0] left,
                              input logic signed [ANGLE_W-1:0] right,
                              input logic [HEAD_W-1:0] heading);
      while (!sender_calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_left_angle  <= left;
      req_right_angle <= right;
      req_compass     <= heading;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stops offering samples and waits until every predicted result has come back. The
   // count is read at the falling edge, where it is settled.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Writes one register. The valid stays high so that writes can run back to back.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Changes the setup while the block is idle. A start position write also clears the
   // reference, so the sample after it only latches new encoder and compass readings.
   task automatic reconfigure(input bit move_start, input logic [DATA_W-1:0] sx,
                              input logic [DATA_W-1:0] sy, input logic [DATA_W-1:0] wheel,
                              input bit poke_spare);
      drain();
      write_reg(CSR_WHEEL, wheel);
      if (move_start) begin
         write_reg(CSR_START_X, sx);
         write_reg(CSR_START_Y, sy);
      end
      if (poke_spare)
         write_reg(CSR_SPARE, $urandom);
      csr_valid <= 1'b0;
   endtask

   // Random driving. Most samples are a plausible next reading: both wheels turn mostly
   // forward by up to about 80 degrees and the heading drifts a little. The rest are noise
   // (arbitrary readings, compass out of range included), repeated readings and sudden
   // heading jumps that exercise the wrap of the heading change.
   task automatic roam(input int count, input int start_head);
      int n;
      int roll;
      int step;
      cur_head = start_head;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 80) begin
            step      = int'($urandom_range(24000)) - 4000;
            cur_left  = cur_left + step;
            cur_right = cur_right + step + int'($urandom_range(4000)) - 2000;
            cur_head  = (cur_head + int'($urandom_range(3000)) - 1500 + 92160) % 92160;
         end else if (roll < 90) begin
            cur_left  = $urandom;
            cur_right = $urandom;
            cur_head  = $urandom_range(131071);
         end else if (roll < 95) begin
            // Same readings again: the robot stands still.
         end else begin
            cur_head = $urandom_range(92159);
         end
         send_sample(cur_left, cur_right, HEAD_W'(cur_head));
      end
   endtask

   // The result side: random stalls, a stall-free window and one long hold-off.
   initial begin : receiver
      int beats_seen;
      int hold_left;
      beats_seen = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (beats_seen == HOLD_AFTER)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (beats_seen >= CALM_FROM && beats_seen < CALM_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 12);
         end
      end
   end

   // Ends the run if no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed samples at the reset setup (start at the origin, 20 cm wheel). Angles are
      // degrees with 8 fraction bits.
      // The first sample only latches the reference.
      send_sample(32'sd0, 32'sd0, 17'd0);
      // One full wheel turn straight north.
      send_sample(32'sd92160, 32'sd92160, 17'd0);
      // Left wheel only, heading swings to east.
      send_sample(32'sd184320, 32'sd92160, 17'd23040);
      // Heading change above a half turn wraps to a negative change.
      send_sample(32'sd184320, 32'sd184320, 17'd89600);
      // Heading change below minus a half turn wraps to a positive change.
      send_sample(32'sd276480, 32'sd276480, 17'd2560);
      // Exactly plus and minus a half turn are taken as they are, the second one backward.
      send_sample(32'sd276480, 32'sd276480, 17'd48640);
      send_sample(32'sd200000, 32'sd200000, 17'd2560);
      // Largest valid compass reading.
      send_sample(32'sd200000, 32'sd200000, 17'd92159);
      // Turn in place with the compass at its largest raw code, out of range.
      send_sample(32'sd300000, 32'sd100000, 17'd131071);
      // Back to north: the change wraps once only and the mid heading is still reduced.
      send_sample(32'sd300000, 32'sd100000, 17'd0);
      // Encoder extremes and full scale jumps in both directions.
      send_sample(32'sh7fffffff, 32'sh80000000, 17'd100000);
      send_sample(32'sh80000000, 32'sh7fffffff, 17'd100000);
      send_sample(32'sh7fffffff, 32'sh7fffffff, 17'd100000);
      send_sample(32'sh80000000, 32'sh80000000, 17'd0);
      send_sample(-32'sd1, -32'sd1, 17'd1);

      // Start at the top corner with the largest wheel and head north-east: both
      // accumulators run into the positive limit. The spare index is written as well.
      cur_left  = '0;
      cur_right = '0;
      reconfigure(1'b1, 32'h7fffffff, 32'h7fffff00, 32'd65535, 1'b1);
      roam(100, 11520);

      // Start at the bottom corner and head south-west toward the negative limit.
      reconfigure(1'b1, 32'h80000000, 32'h80000100, 32'd65535, 1'b0);
      roam(100, 57600);

      // A zero circumference freezes the position. Only the wheel register is written,
      // so the reference is kept and no sample reports as first.
      reconfigure(1'b0, '0, '0, 32'd0, 1'b0);
      roam(60, 30000);

      // Smallest circumference, random start.
      reconfigure(1'b1, $urandom, $urandom, 32'd1, 1'b1);
      roam(80, 70000);

      // Random setup with the sender offering back to back.
      reconfigure(1'b1, $urandom, $urandom, $urandom_range(65535, 1), 1'b0);
      sender_calm = 1'b1;
      roam(130, 0);
      sender_calm = 1'b0;

      // Reset values again.
      reconfigure(1'b1, 32'd0, 32'd0, 32'd5120, 1'b0);
      roam(130, 46080);

      // Full random write data: the upper bits of the wheel write are ignored.
      reconfigure(1'b1, $urandom, 32'hffffffff, $urandom, 1'b1);
      roam(135, 80000);

      drain();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
